/* src/jkv_pkg.sv */
// shared types and constants of the json key/value extractor
package jkv_pkg;

	// parse phases of one document
	typedef enum logic [3:0] {
		PH_SEARCH,
		PH_COLON,
		PH_INT_SEEK,
		PH_INT_DIGITS,
		PH_INT_DONE,
		PH_BOOL_SEEK,
		PH_BOOL_T,
		PH_BOOL_F,
		PH_BOOL_FAIL,
		PH_BOOL_TRUE,
		PH_BOOL_FALSE,
		PH_STR_SEEK,
		PH_STR_BODY,
		PH_STR_DONE
	} phase_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_FOUND,
		ST_NO_KEY,
		ST_NO_COLON,
		ST_ABSENT
	} status_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_KEY_LOW,
		REG_KEY_MID,
		REG_KEY_HIGH,
		REG_KEY_TAIL,
		REG_KEY_LENGTH,
		REG_VALUE_MODE,
		REG_DEFAULT
	} reg_index_t;

	localparam logic [1:0] MODE_INT  = 2'd0;
	localparam logic [1:0] MODE_BOOL = 2'd1;
	localparam logic [1:0] MODE_STR  = 2'd2;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG9   = 8'h39;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;

	// characters of the literal true
	function automatic logic [7:0] lit_true(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h74;
			3'd1: ch = 8'h72;
			3'd2: ch = 8'h75;
			3'd3: ch = 8'h65;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// characters of the literal false
	function automatic logic [7:0] lit_false(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h66;
			3'd1: ch = 8'h61;
			3'd2: ch = 8'h6c;
			3'd3: ch = 8'h73;
			3'd4: ch = 8'h65;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* src/jkv_key_match.sv */
// parallel compare of the byte window against the quoted key
module jkv_key_match #(
	parameter int KEY_MAX = 29
) (
	input  logic [(KEY_MAX+2)*8-1:0] win,        // newest byte in the lowest byte
	input  logic [KEY_MAX*8-1:0]     key,        // first key character in the lowest byte
	input  logic [4:0]               key_length,
	output logic                     match
);

	localparam int LEN_W = (KEY_MAX + 1 > 2) ? $clog2(KEY_MAX + 1) : 1;

	logic [KEY_MAX:0] cand;
	logic [LEN_W-1:0] len;

	// one candidate per possible key length
	for (genvar L = 0; L <= KEY_MAX; L++) begin : g_len
		logic [L:0] hit;
		assign hit[0] = (win[7:0] == jkv_pkg::CH_QUOTE)
			&& (win[(L+1)*8 +: 8] == jkv_pkg::CH_QUOTE);
		for (genvar i = 0; i < L; i++) begin : g_chr
			assign hit[i+1] = (win[(L-i)*8 +: 8] == key[i*8 +: 8]);
		end
		assign cand[L] = &hit;
	end

	// length in use: clamped, and cut at the first zero character
	always_comb begin
		logic [4:0] n;
		n = (key_length > 5'(KEY_MAX)) ? 5'(KEY_MAX) : key_length;
		len = n[LEN_W-1:0];
		for (int k = KEY_MAX - 1; k >= 0; k--) begin
			if ((5'(k) < n) && (key[k*8 +: 8] == 8'h00)) begin
				len = LEN_W'(k);
			end
		end
	end

	assign match = cand[len];

endmodule

/* src/json_key_value_extractor.sv */
// json key/value extractor top level
//
// usage
//   s_axis: one document byte per transfer in tdata, tlast on the final byte.
//   a zero byte ends the text early; bytes after it are ignored until tlast.
//   cfg: register writes (index, data), always ready; write only while idle.
//   m_axis: one result per document, presented after the tlast byte.
// timing
//   accepted bytes land in an input register and are parsed from there; the
//   result of the tlast byte is loaded into the output register for m_axis.
//   throughput is one byte per cycle unless a tlast byte is held back, one
//   parse step per byte (window compare against key, times-ten accumulate).
// stalls
//   a result waits in the output register; bytes keep flowing meanwhile and
//   only the next tlast byte is held back while the previous result is unread.
// reset
//   arst_n clears the parse state and the pipeline valids; registers return to
//   key empty, integer mode, default value -1.
module json_key_value_extractor #(
	parameter int KEY_MAX       = 29,
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // doc_byte
	input  logic        s_axis_tlast,   // doc_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], int_value[33:2], bool_value[34], string_offset[50:35],
	// string_length[66:51], zero fill[71:67]
	output logic [71:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int WIN_BYTES = KEY_MAX + 2;
	localparam int WIN_W     = WIN_BYTES * 8;
	localparam int POS_W     = (POSITION_BITS < 16) ? POSITION_BITS : 16;

	// configuration registers
	logic [63:0] key_low_q, key_mid_q, key_high_q;
	logic [39:0] key_tail_q;
	logic [4:0]  key_length_q;
	logic [1:0]  value_mode_q;
	logic [31:0] default_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       step;

	// document state
	jkv_pkg::phase_t phase_q, phase_n;
	logic [WIN_W-1:0] win_q, win_n, win_sh;
	logic [POS_W-1:0] pos_q, pos_n, start_q, start_n, count_q, count_n;
	logic [31:0] acc_q, acc_n;
	logic        neg_q, neg_n, esc_q, esc_n, ended_q, ended_n;
	logic [2:0]  lit_q, lit_n;
	logic        match;

	// output stage
	logic        out_valid_q;
	logic [71:0] out_data_q;
	logic [71:0] result;

	logic [231:0] key_all;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= '0;
			key_mid_q    <= '0;
			key_high_q   <= '0;
			key_tail_q   <= '0;
			key_length_q <= '0;
			value_mode_q <= jkv_pkg::MODE_INT;
			default_q    <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jkv_pkg::REG_KEY_LOW:    key_low_q    <= cfg_data;
				jkv_pkg::REG_KEY_MID:    key_mid_q    <= cfg_data;
				jkv_pkg::REG_KEY_HIGH:   key_high_q   <= cfg_data;
				jkv_pkg::REG_KEY_TAIL:   key_tail_q   <= cfg_data[39:0];
				jkv_pkg::REG_KEY_LENGTH: key_length_q <= cfg_data[4:0];
				jkv_pkg::REG_VALUE_MODE: value_mode_q <= cfg_data[1:0];
				jkv_pkg::REG_DEFAULT:    default_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// a non-final byte never needs the output register, so only tlast can stall
	assign step          = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// key compare on the window with the current byte shifted in
	assign key_all = {key_tail_q, key_high_q, key_mid_q, key_low_q};
	assign win_sh  = {win_q[WIN_W-9:0], byte_s1};

	jkv_key_match #(
		.KEY_MAX(KEY_MAX)
	) u_match (
		.win       (win_sh),
		.key       (key_all[KEY_MAX*8-1:0]),
		.key_length(key_length_q),
		.match     (match)
	);

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// one parse step per byte
	always_comb begin
		logic is_digit;
		is_digit = (byte_s1 >= jkv_pkg::CH_DIG0) && (byte_s1 <= jkv_pkg::CH_DIG9);
		phase_n = phase_q;
		win_n   = win_q;
		pos_n   = pos_q;
		start_n = start_q;
		count_n = count_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		esc_n   = esc_q;
		ended_n = ended_q;
		lit_n   = lit_q;
		if (!ended_q) begin
			if (byte_s1 == 8'h00) begin
				ended_n = 1'b1;
			end else begin
				unique case (phase_q)
					jkv_pkg::PH_SEARCH: begin
						win_n = win_sh;
						if (match) phase_n = jkv_pkg::PH_COLON;
					end
					jkv_pkg::PH_COLON: begin
						if (byte_s1 == jkv_pkg::CH_COLON) begin
							if (value_mode_q == jkv_pkg::MODE_INT)
								phase_n = jkv_pkg::PH_INT_SEEK;
							else if (value_mode_q == jkv_pkg::MODE_BOOL)
								phase_n = jkv_pkg::PH_BOOL_SEEK;
							else
								phase_n = jkv_pkg::PH_STR_SEEK;
						end
					end
					jkv_pkg::PH_INT_SEEK: begin
						if (is_digit) begin
							acc_n   = {28'd0, byte_s1[3:0]};
							phase_n = jkv_pkg::PH_INT_DIGITS;
						end else if (byte_s1 == jkv_pkg::CH_MINUS) begin
							neg_n   = 1'b1;
							phase_n = jkv_pkg::PH_INT_DIGITS;
						end
					end
					jkv_pkg::PH_INT_DIGITS: begin
						// times ten as two shifts, wrapping at 32 bits
						if (is_digit)
							acc_n = (acc_q << 3) + (acc_q << 1) + {28'd0, byte_s1[3:0]};
						else
							phase_n = jkv_pkg::PH_INT_DONE;
					end
					jkv_pkg::PH_BOOL_SEEK: begin
						if (byte_s1 != jkv_pkg::CH_SPACE && byte_s1 != jkv_pkg::CH_TAB) begin
							lit_n = 3'd1;
							if (byte_s1 == jkv_pkg::CH_T)
								phase_n = jkv_pkg::PH_BOOL_T;
							else if (byte_s1 == jkv_pkg::CH_F)
								phase_n = jkv_pkg::PH_BOOL_F;
							else
								phase_n = jkv_pkg::PH_BOOL_FAIL;
						end
					end
					jkv_pkg::PH_BOOL_T: begin
						if (lit_q < 3'd4 && byte_s1 == jkv_pkg::lit_true(lit_q)) begin
							lit_n = lit_q + 3'd1;
							if (lit_q == 3'd3) phase_n = jkv_pkg::PH_BOOL_TRUE;
						end else begin
							phase_n = jkv_pkg::PH_BOOL_FAIL;
						end
					end
					jkv_pkg::PH_BOOL_F: begin
						if (lit_q < 3'd5 && byte_s1 == jkv_pkg::lit_false(lit_q)) begin
							lit_n = lit_q + 3'd1;
							if (lit_q == 3'd4) phase_n = jkv_pkg::PH_BOOL_FALSE;
						end else begin
							phase_n = jkv_pkg::PH_BOOL_FAIL;
						end
					end
					jkv_pkg::PH_STR_SEEK: begin
						if (byte_s1 == jkv_pkg::CH_QUOTE) begin
							start_n = sat_inc(pos_q);
							phase_n = jkv_pkg::PH_STR_BODY;
						end
					end
					jkv_pkg::PH_STR_BODY: begin
						// an escaped byte counts even when it is a quote
						if (esc_q) begin
							esc_n   = 1'b0;
							count_n = sat_inc(count_q);
						end else if (byte_s1 == jkv_pkg::CH_QUOTE) begin
							phase_n = jkv_pkg::PH_STR_DONE;
						end else begin
							if (byte_s1 == jkv_pkg::CH_BSLASH) esc_n = 1'b1;
							count_n = sat_inc(count_q);
						end
					end
					default: ;
				endcase
				pos_n = sat_inc(pos_q);
			end
		end
	end

	// result from the state after this byte
	always_comb begin
		jkv_pkg::status_t st;
		logic [31:0] ival;
		logic        bval;
		logic [15:0] soff, slen;
		ival = default_q;
		bval = (default_q != 32'd0);
		soff = '0;
		slen = '0;
		unique case (phase_n)
			jkv_pkg::PH_SEARCH: st = jkv_pkg::ST_NO_KEY;
			jkv_pkg::PH_COLON:  st = jkv_pkg::ST_NO_COLON;
			jkv_pkg::PH_INT_DIGITS, jkv_pkg::PH_INT_DONE: begin
				st   = jkv_pkg::ST_FOUND;
				ival = neg_n ? (32'd0 - acc_n) : acc_n;
			end
			jkv_pkg::PH_BOOL_TRUE: begin
				st   = jkv_pkg::ST_FOUND;
				bval = 1'b1;
			end
			jkv_pkg::PH_BOOL_FALSE: begin
				st   = jkv_pkg::ST_FOUND;
				bval = 1'b0;
			end
			jkv_pkg::PH_STR_BODY, jkv_pkg::PH_STR_DONE: begin
				st   = jkv_pkg::ST_FOUND;
				soff = 16'(start_n);
				slen = 16'(count_n);
			end
			default: st = jkv_pkg::ST_ABSENT;
		endcase
		result = {5'd0, slen, soff, bval, ival, st};
	end

	// document state; cleared after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jkv_pkg::PH_SEARCH;
			win_q   <= '0;
			pos_q   <= '0;
			start_q <= '0;
			count_q <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			esc_q   <= 1'b0;
			ended_q <= 1'b0;
			lit_q   <= '0;
		end else if (step) begin
			if (last_s1) begin
				phase_q <= jkv_pkg::PH_SEARCH;
				win_q   <= '0;
				pos_q   <= '0;
				start_q <= '0;
				count_q <= '0;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				esc_q   <= 1'b0;
				ended_q <= 1'b0;
				lit_q   <= '0;
			end else begin
				phase_q <= phase_n;
				win_q   <= win_n;
				pos_q   <= pos_n;
				start_q <= start_n;
				count_q <= count_n;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				esc_q   <= esc_n;
				ended_q <= ended_n;
				lit_q   <= lit_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// every document starts over from the key search
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> (phase_q == jkv_pkg::PH_SEARCH && !ended_q))
		else $error("parse state not cleared after final byte");

	// input only stalls behind an unread result and a waiting final byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a pending result");

	// a result is loaded only on a final byte
	a_result_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q)) |-> $past(step && last_s1))
		else $error("result produced without final byte");

	// apart from the clear on a final byte, the window only moves in key search
	a_window_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !last_s1 && phase_q != jkv_pkg::PH_SEARCH) |=> $stable(win_q))
		else $error("window changed outside key search");
`endif

endmodule
